// ===== sv/hbfn_pkg.sv =====
`timescale 1ns / 1ps

package hbfn_pkg;

	localparam int WORD_W  = 64;
	localparam int PTR_W   = 6;
	localparam int IDX_W   = 13;
	localparam int FOUND_W = 14;

	localparam logic [IDX_W-1:0] UNIVERSE_SIZE = 13'd4096;
	localparam logic [IDX_W-1:0] MIN_SIZE      = 13'd1;

	typedef enum logic [2:0] {
		OP_TEST      = 3'd0,
		OP_SET       = 3'd1,
		OP_CLEAR     = 3'd2,
		OP_FIND_NEXT = 3'd3,
		OP_FIND_PREV = 3'd4,
		OP_CLEAR_ALL = 3'd5,
		OP_FILL_ALL  = 3'd6
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LEAF,
		ST_NEXT_LEAF,
		ST_OUT
	} state_t;

	function automatic logic [PTR_W-1:0] low_bit(input logic [WORD_W-1:0] v);
		logic [PTR_W-1:0] n;
		n = '0;
		for (int k = WORD_W - 1; k >= 0; k--) begin
			if (v[k]) begin
				n = PTR_W'(k);
			end
		end
		return n;
	endfunction

	function automatic logic [PTR_W-1:0] high_bit(input logic [WORD_W-1:0] v);
		logic [PTR_W-1:0] n;
		n = '0;
		for (int k = 0; k < WORD_W; k++) begin
			if (v[k]) begin
				n = PTR_W'(k);
			end
		end
		return n;
	endfunction

endpackage

// ===== sv/hierarchical_bitmap_find_next_top.sv =====
`timescale 1ns / 1ps

// Two-level bitmap over 4096 indices: 64 leaf words of 64 bits in a synchronous memory and
// one 64-bit summary word with a bit for each non-empty leaf. Each input transfer carries an
// operation (test, set, clear, find next, find previous, clear all, fill all) and an index,
// and gives exactly one output transfer. An item passes through accept and leaf read, then
// evaluation, then hand-over to the output register, which waits while that register still
// holds an untaken result; a search that must skip to another leaf word adds a read and an
// evaluation of that word before the hand-over. The leaf memory has a registered read port
// and is read once per leaf visited. Clear all and fill all take effect at once through a
// valid bit per leaf word, so no clearing pass is needed after reset. A new input transfer is
// accepted only in the idle state, and also while a result still waits in the output register.
module hierarchical_bitmap_find_next_top
	import hbfn_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [IDX_W-1:0]  cfg_wdata,   // size_in_use
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [15:0]       s_tdata,     // op [2:0], index [15:3]
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [15:0]       m_tdata      // found_index [13:0], is_member [14], none_found [15]
);

	logic [WORD_W-1:0] leaf_mem [WORD_W];
	logic [WORD_W-1:0] rd_data_q;

	state_t            state_q, state_d;
	logic [IDX_W-1:0]  size_q;
	logic [WORD_W-1:0] summary_q;
	logic [WORD_W-1:0] valid_q;
	logic              fill_q;

	op_t               op_s1;
	logic [PTR_W-1:0]  word_s1;
	logic [PTR_W-1:0]  bit_s1;
	logic              ok_s1;

	logic [FOUND_W-1:0] res_found_q;
	logic               res_member_q;
	logic               res_none_q;
	logic               m_tvalid_q;
	logic [15:0]        m_tdata_q;

	logic [IDX_W-1:0]  sz;
	op_t               in_op;
	logic [IDX_W-1:0]  in_idx;
	logic [IDX_W-1:0]  lim;
	logic [IDX_W-1:0]  prev_j;
	logic [IDX_W-1:0]  start_idx;
	logic              in_ok;

	logic              rd_en;
	logic [PTR_W-1:0]  rd_addr;
	logic              mem_we;
	logic [WORD_W-1:0] mem_wdata;
	logic              go_second;
	logic              wipe;
	logic              fill;
	logic              sum_set;
	logic              sum_clr;
	logic              load_res;
	logic              out_load;
	logic [FOUND_W-1:0] res_found_d;
	logic               res_member_d;
	logic               res_none_d;

	logic [WORD_W-1:0] leaf_word;
	logic [WORD_W-1:0] bit_mask;
	logic [WORD_W-1:0] hit;
	logic [WORD_W-1:0] skip;
	logic [PTR_W-1:0]  hit_bit;
	logic [PTR_W-1:0]  skip_word;

	always_comb begin
		if (size_q == '0) begin
			sz = MIN_SIZE;
		end else if (size_q > UNIVERSE_SIZE) begin
			sz = UNIVERSE_SIZE;
		end else begin
			sz = size_q;
		end
	end

	assign in_op     = op_t'(s_tdata[2:0]);
	assign in_idx    = s_tdata[15:3];
	assign lim       = (in_idx < sz) ? in_idx : sz;
	assign prev_j    = lim - IDX_W'(1);
	assign start_idx = (in_op == OP_FIND_PREV) ? prev_j : in_idx;
	assign in_ok     = (in_op == OP_FIND_PREV) ? (lim != '0) : (in_idx < sz);

	assign leaf_word = valid_q[word_s1] ? rd_data_q : {WORD_W{fill_q}};
	assign bit_mask  = {{(WORD_W-1){1'b0}}, 1'b1} << bit_s1;
	assign hit_bit   = (op_s1 == OP_FIND_PREV) ? high_bit(hit) : low_bit(hit);
	assign skip_word = (op_s1 == OP_FIND_PREV) ? high_bit(skip) : low_bit(skip);

	always_comb begin
		if (op_s1 == OP_FIND_PREV) begin
			hit  = leaf_word & ({WORD_W{1'b1}} >> (~bit_s1));
			skip = summary_q & ~({WORD_W{1'b1}} << word_s1);
		end else begin
			hit  = leaf_word & ({WORD_W{1'b1}} << bit_s1);
			skip = summary_q & (({WORD_W{1'b1}} << word_s1) << 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		s_tready     = 1'b0;
		rd_en        = 1'b0;
		rd_addr      = start_idx[2*PTR_W-1:PTR_W];
		mem_we       = 1'b0;
		mem_wdata    = leaf_word | bit_mask;
		go_second    = 1'b0;
		wipe         = 1'b0;
		fill         = 1'b0;
		sum_set      = 1'b0;
		sum_clr      = 1'b0;
		load_res     = 1'b0;
		out_load     = 1'b0;
		res_found_d  = '0;
		res_member_d = 1'b0;
		res_none_d   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					rd_en   = 1'b1;
					state_d = ST_LEAF;
				end
			end
			ST_LEAF: begin
				load_res = 1'b1;
				state_d  = ST_OUT;
				case (op_s1)
					OP_TEST: begin
						res_member_d = ok_s1 & leaf_word[bit_s1];
					end
					OP_SET: begin
						mem_we    = ok_s1;
						mem_wdata = leaf_word | bit_mask;
						sum_set   = ok_s1;
					end
					OP_CLEAR: begin
						mem_we    = ok_s1;
						mem_wdata = leaf_word & ~bit_mask;
						sum_clr   = ok_s1 && ((leaf_word & ~bit_mask) == '0);
					end
					OP_FIND_NEXT, OP_FIND_PREV: begin
						if (!ok_s1) begin
							res_none_d = 1'b1;
						end else if (hit != '0) begin
							res_found_d = {2'b00, word_s1, hit_bit};
						end else if (skip == '0) begin
							res_none_d = 1'b1;
						end else begin
							rd_en     = 1'b1;
							rd_addr   = skip_word;
							go_second = 1'b1;
							load_res  = 1'b0;
							state_d   = ST_NEXT_LEAF;
						end
					end
					OP_CLEAR_ALL: begin
						wipe = 1'b1;
					end
					OP_FILL_ALL: begin
						fill = 1'b1;
					end
					default: begin
					end
				endcase
			end
			ST_NEXT_LEAF: begin
				load_res = 1'b1;
				state_d  = ST_OUT;
				if (leaf_word == '0) begin
					res_none_d = 1'b1;
				end else begin
					res_found_d = {2'b00, word_s1, hit_bit};
				end
			end
			ST_OUT: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (load_res && (op_s1 == OP_FIND_NEXT)) begin
			if (res_none_d || (res_found_d[IDX_W-1:0] >= sz)) begin
				res_none_d  = 1'b1;
				res_found_d = {1'b0, sz};
			end
		end else if (load_res && (op_s1 == OP_FIND_PREV) && res_none_d) begin
			res_found_d = '1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			leaf_mem[word_s1] <= mem_wdata;
		end
		if (rd_en) begin
			rd_data_q <= leaf_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1   <= in_op;
			word_s1 <= start_idx[2*PTR_W-1:PTR_W];
			bit_s1  <= start_idx[PTR_W-1:0];
			ok_s1   <= in_ok;
		end else if (go_second) begin
			word_s1 <= skip_word;
			bit_s1  <= (op_s1 == OP_FIND_PREV) ? {PTR_W{1'b1}} : {PTR_W{1'b0}};
		end
		if (load_res) begin
			res_found_q  <= res_found_d;
			res_member_q <= res_member_d;
			res_none_q   <= res_none_d;
		end
		if (out_load) begin
			m_tdata_q <= {res_none_q, res_member_q, res_found_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q     <= UNIVERSE_SIZE;
			summary_q  <= '0;
			valid_q    <= '0;
			fill_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				size_q <= cfg_wdata;
			end
			if (wipe || fill) begin
				summary_q <= {WORD_W{fill}};
				valid_q   <= '0;
				fill_q    <= fill;
			end else begin
				if (sum_set) begin
					summary_q[word_s1] <= 1'b1;
				end else if (sum_clr) begin
					summary_q[word_s1] <= 1'b0;
				end
				if (mem_we) begin
					valid_q[word_s1] <= 1'b1;
				end
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_set_marks_summary: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LEAF && op_s1 == OP_SET && ok_s1) |=> summary_q[$past(word_s1)])
		else $error("set did not mark the summary bit");

	a_fill_marks_all: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LEAF && op_s1 == OP_FILL_ALL) |=> (&summary_q && valid_q == '0))
		else $error("fill all left the summary incomplete");

	a_out_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && m_tvalid_q && !m_tready) |=> (state_q == ST_OUT))
		else $error("result left its holding state while the output was stalled");

	a_none_not_member: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[15]) |-> !m_tdata[14])
		else $error("a failed search also reported membership");

endmodule
